// ===== rtl/mcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcc_pkg
// Shared widths, codes and types for the minimum-coin change engine.
// ----------------------------------------------------------------------------
package mcc_pkg;

  localparam int AMT_W      = 10;   // target amount
  localparam int VALUE_W    = 10;   // coin denomination
  localparam int SLOT_W     = 3;    // coin slot index
  localparam int CNT_W      = 11;   // table coin count
  localparam int TALLY_W    = 10;   // per-slot tally
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam int VALUE_REGS         = 6;
  localparam int MAX_AMOUNT_DEFAULT = 1023;
  localparam int COIN_SLOTS_DEFAULT = 6;

  localparam logic [CNT_W-1:0]   UNREACH   = 11'h7FF;
  localparam logic [CNT_W-1:0]   COUNT_SAT = 11'h7FE;
  localparam logic [TALLY_W-1:0] TALLY_SAT = 10'h3FF;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_COIN_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_LAST = 3'd6;

  typedef enum logic [STATUS_W-1:0] {
    ST_GROUP   = 2'd0,
    ST_ZERO    = 2'd1,
    ST_UNREACH = 2'd2
  } status_t;

  typedef struct packed {
    logic [CNT_W-1:0]  best;
    logic [SLOT_W-1:0] pick;
  } mcc_entry_t;

endpackage

// ===== rtl/mcc_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcc channel interfaces
// Request, result and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mcc_in_if;
  import mcc_pkg::*;
  logic               valid;
  logic               ready;
  logic [AMT_W-1:0]   target_amount;
  modport source (output valid, output target_amount, input ready);
  modport sink   (input valid, input target_amount, output ready);
endinterface

interface mcc_out_if;
  import mcc_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_index;
  logic [VALUE_W-1:0]  slot_value;
  logic [TALLY_W-1:0]  used_count;
  logic                last_group;
  modport source (output valid, output status, output slot_index, output slot_value,
                  output used_count, output last_group, input ready);
  modport sink   (input valid, input status, input slot_index, input slot_value,
                  input used_count, input last_group, output ready);
endinterface

interface mcc_cfg_if;
  import mcc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/min_coin_change_dp_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_coin_change_dp_top
// Minimum-coin change engine: table fill, traceback and per-slot report.
// ----------------------------------------------------------------------------
// Usage
//   in_if  : one transaction carries a target amount. in_if.ready is high only
//            while the engine is idle.
//   out_if : one or more result transactions per request, ascending slot
//            order, last_group set on the final one. Amount zero and an
//            unreachable amount give one status result each.
//   cfg_if : register writes (index 0 coin count, 1..6 coin values), always
//            ready; write only while no request is in flight.
// Sequence
//   Fill: a setup step, then per amount step six slot reads, a compare
//   drain and the table write-back.
//   Traceback: per coin, a table read, then a tally update.
//   Report: one coin slot at a time, plus waits on the output register.
// Reset
//   Coin count 1, all coin values 1, tallies cleared, no result pending.
//   The table memory is not cleared: each request rewrites it from 0 up.
// Stalls
//   The output register holds a result until taken; the report step waits
//   on it. A new request is accepted while the last result still waits.
// ----------------------------------------------------------------------------
module min_coin_change_dp_top #(
  parameter int MAX_AMOUNT = mcc_pkg::MAX_AMOUNT_DEFAULT,
  parameter int COIN_SLOTS = mcc_pkg::COIN_SLOTS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  mcc_in_if.sink     in_if,
  mcc_out_if.source  out_if,
  mcc_cfg_if.sink    cfg_if
);
  import mcc_pkg::*;

  localparam int AMT_TOP  = (1 << AMT_W) - 1;
  localparam int EFF_MAX  = (MAX_AMOUNT < AMT_TOP) ? MAX_AMOUNT : AMT_TOP;
  localparam int DEPTH    = EFF_MAX + 1;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SLOT_LIM = (COIN_SLOTS < VALUE_REGS) ? COIN_SLOTS : VALUE_REGS;
  localparam logic [SLOT_W-1:0] J_DONE = SLOT_W'(VALUE_REGS);

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_FILL, S_WRITE, S_TR_RD, S_TR_CHK, S_EMIT, S_STATUS
  } state_t;

  state_t              state_r;
  logic [AMT_W-1:0]    amt_r;
  logic [AMT_W-1:0]    a_r;
  logic [AMT_W-1:0]    k_r;
  logic [SLOT_W-1:0]   j_r;
  logic [SLOT_W-1:0]   e_r;
  logic                valid_p_r;
  logic [SLOT_W-1:0]   pick_p_r;
  logic [CNT_W-1:0]    best_r;
  logic [SLOT_W-1:0]   pick_r;
  status_t             stat_r;
  logic [TALLY_W-1:0]  tally_r [VALUE_REGS];

  logic [SLOT_W-1:0]   coin_count_r;
  logic [VALUE_W-1:0]  coin_value_r [VALUE_REGS];

  logic                out_valid_r;
  status_t             out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [VALUE_W-1:0]  out_value_r;
  logic [TALLY_W-1:0]  out_count_r;
  logic                out_last_r;

  // table memory: one write port, one registered read port
  mcc_entry_t          tbl_mem [DEPTH];
  mcc_entry_t          rd_q_r;
  logic                tbl_we;
  logic [AW-1:0]       tbl_waddr;
  mcc_entry_t          tbl_wdata;
  logic [AW-1:0]       rd_addr;

  logic [SLOT_W-1:0]   slots_act;
  logic [VALUE_W-1:0]  cur_v;
  logic                issue_ok;
  logic [CNT_W-1:0]    cand;
  logic                hit;
  logic [SLOT_W-1:0]   tr_slot;
  logic [VALUE_W-1:0]  tr_v;
  logic                tr_bad;
  logic                any_tally;
  logic                higher_nz;
  logic                out_free;
  logic                out_load;
  logic                in_acc;

  assign in_acc   = in_if.valid && in_if.ready;
  assign out_free = !out_valid_r || out_if.ready;

  // a new result enters the output register this cycle
  assign out_load = out_free &&
                    (((state_r == S_EMIT) && any_tally && (tally_r[e_r] != '0)) ||
                     (state_r == S_STATUS));

  assign in_if.ready       = (state_r == S_IDLE);
  assign cfg_if.ready      = 1'b1;
  assign out_if.valid      = out_valid_r;
  assign out_if.status     = out_status_r;
  assign out_if.slot_index = out_slot_r;
  assign out_if.slot_value = out_value_r;
  assign out_if.used_count = out_count_r;
  assign out_if.last_group = out_last_r;

  // slots in use, limited by the slot parameter and the value registers
  assign slots_act = (int'(coin_count_r) > SLOT_LIM) ? SLOT_W'(SLOT_LIM) : coin_count_r;

  assign cur_v    = (j_r < J_DONE) ? coin_value_r[j_r] : '0;
  assign issue_ok = (state_r == S_FILL) && (j_r < slots_act) &&
                    (cur_v != '0) && (cur_v <= a_r);

  assign hit  = valid_p_r && (rd_q_r.best != UNREACH);
  assign cand = (rd_q_r.best == COUNT_SAT) ? COUNT_SAT : rd_q_r.best + CNT_W'(1);

  assign tr_slot = rd_q_r.pick;
  assign tr_v    = (tr_slot < J_DONE) ? coin_value_r[tr_slot] : '0;
  assign tr_bad  = (tr_v == '0) || (tr_v > k_r);

  always_comb begin
    any_tally = 1'b0;
    higher_nz = 1'b0;
    for (int j = 0; j < VALUE_REGS; j++) begin
      if (tally_r[j] != '0) begin
        any_tally = 1'b1;
        if (SLOT_W'(j) > e_r) higher_nz = 1'b1;
      end
    end
  end

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = AW'(a_r);
    tbl_wdata = '{best: best_r, pick: pick_r};
    if (state_r == S_INIT) begin
      tbl_we    = 1'b1;
      tbl_waddr = '0;
      tbl_wdata = '{best: '0, pick: '0};
    end else if (state_r == S_WRITE) begin
      tbl_we    = 1'b1;
    end
    rd_addr = (state_r == S_FILL) ? AW'(a_r - cur_v) : AW'(k_r);
  end

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
    rd_q_r <= tbl_mem[rd_addr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coin_count_r <= SLOT_W'(1);
      for (int i = 0; i < VALUE_REGS; i++) coin_value_r[i] <= VALUE_W'(1);
    end else if (cfg_if.valid && cfg_if.ready) begin
      if (cfg_if.index == REG_COIN_COUNT) begin
        coin_count_r <= cfg_if.data[SLOT_W-1:0];
      end else if (cfg_if.index <= REG_VALUE_LAST) begin
        coin_value_r[SLOT_W'(cfg_if.index - CFG_IDX_W'(1))] <= cfg_if.data;
      end
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      valid_p_r   <= 1'b0;
      for (int i = 0; i < VALUE_REGS; i++) tally_r[i] <= '0;
    end else begin
      if (out_load)          out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            amt_r <= in_if.target_amount;
            for (int i = 0; i < VALUE_REGS; i++) tally_r[i] <= '0;
            if (in_if.target_amount == '0) begin
              stat_r  <= ST_ZERO;
              state_r <= S_STATUS;
            end else if (int'(in_if.target_amount) > EFF_MAX) begin
              stat_r  <= ST_UNREACH;
              state_r <= S_STATUS;
            end else begin
              state_r <= S_INIT;
            end
          end
        end

        S_INIT: begin
          a_r       <= AMT_W'(1);
          j_r       <= '0;
          best_r    <= UNREACH;
          pick_r    <= '0;
          valid_p_r <= 1'b0;
          state_r   <= S_FILL;
        end

        S_FILL: begin
          // read issued for slot j_r, compare for the slot before
          valid_p_r <= issue_ok;
          pick_p_r  <= j_r;
          if (hit && (cand < best_r)) begin
            best_r <= cand;
            pick_r <= pick_p_r;
          end
          if (j_r == J_DONE) state_r <= S_WRITE;
          else               j_r     <= j_r + SLOT_W'(1);
        end

        S_WRITE: begin
          valid_p_r <= 1'b0;
          if (a_r == amt_r) begin
            k_r     <= amt_r;
            state_r <= S_TR_RD;
          end else begin
            a_r     <= a_r + AMT_W'(1);
            j_r     <= '0;
            best_r  <= UNREACH;
            pick_r  <= '0;
            state_r <= S_FILL;
          end
        end

        S_TR_RD: state_r <= S_TR_CHK;

        S_TR_CHK: begin
          if (rd_q_r.best == UNREACH) begin
            stat_r  <= ST_UNREACH;
            state_r <= S_STATUS;
          end else if (tr_bad) begin
            e_r     <= '0;
            state_r <= S_EMIT;
          end else begin
            if (tally_r[tr_slot] != TALLY_SAT)
              tally_r[tr_slot] <= tally_r[tr_slot] + TALLY_W'(1);
            k_r <= k_r - tr_v;
            if (k_r == tr_v) begin
              e_r     <= '0;
              state_r <= S_EMIT;
            end else begin
              state_r <= S_TR_RD;
            end
          end
        end

        S_EMIT: begin
          if (!any_tally) begin
            stat_r  <= ST_UNREACH;
            state_r <= S_STATUS;
          end else if (tally_r[e_r] == '0) begin
            e_r <= e_r + SLOT_W'(1);
          end else if (out_free) begin
            out_status_r <= ST_GROUP;
            out_slot_r   <= e_r;
            out_value_r  <= coin_value_r[e_r];
            out_count_r  <= tally_r[e_r];
            out_last_r   <= !higher_nz;
            if (!higher_nz) state_r <= S_IDLE;
            else            e_r     <= e_r + SLOT_W'(1);
          end
        end

        S_STATUS: begin
          if (out_free) begin
            out_status_r <= stat_r;
            out_slot_r   <= '0;
            out_value_r  <= '0;
            out_count_r  <= '0;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/mcc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcc_checker
// Port-level checks on the minimum-coin change engine, bound to the top.
// ----------------------------------------------------------------------------
module mcc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [mcc_pkg::STATUS_W-1:0]  status,
  input logic [mcc_pkg::SLOT_W-1:0]    slot_index,
  input logic [mcc_pkg::VALUE_W-1:0]   slot_value,
  input logic [mcc_pkg::TALLY_W-1:0]   used_count,
  input logic                          last_group
);
  import mcc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable(status) && $stable(slot_index) && $stable(slot_value) &&
      $stable(used_count) && $stable(last_group))
    else $error("result changed while stalled");

  // the engine is busy right after taking a request
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // status results stand alone with zeroed payload
  a_status_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ST_GROUP) |->
      last_group && (slot_index == '0) && (slot_value == '0) && (used_count == '0))
    else $error("malformed status result");

  // a coin group always reports real coins
  a_group_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_GROUP) |-> (used_count != '0) && (slot_value != '0))
    else $error("empty coin group");

endmodule

bind min_coin_change_dp_top mcc_checker u_mcc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .status     (out_if.status),
  .slot_index (out_if.slot_index),
  .slot_value (out_if.slot_value),
  .used_count (out_if.used_count),
  .last_group (out_if.last_group)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the minimum-coin change engine. Amounts are
// queued per coin setting. Every accepted request is planned by a local
// table-fill and traceback model; each returned coin group is compared field
// by field. Both channels idle in short random bursts, except the final phase.
// ----------------------------------------------------------------------------
module tb_top;
  import mcc_pkg::*;

  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int TAIL_CYCLES = 50;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_IDX_W'(REG_VALUE_LAST + 1);

  typedef logic [VALUE_REGS-1:0][VALUE_W-1:0] coin_set_t;

  typedef struct {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] value;
    logic [TALLY_W-1:0] count;
    logic               last;
  } coin_group_t;

  logic clk;
  logic rst_n;

  mcc_in_if  in_ch ();
  mcc_out_if out_ch ();
  mcc_cfg_if cfg_ch ();

  min_coin_change_dp_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // local copy of the coin registers
  logic [2:0]         denom_count;
  logic [VALUE_W-1:0] denom [VALUE_REGS];

  logic [AMT_W-1:0] amounts_pending[$];
  coin_group_t      groups_due[$];
  coin_group_t      want;

  int  requests_queued = 0;
  int  requests_sent   = 0;
  int  requests_done   = 0;
  int  groups_seen     = 0;
  int  mismatches      = 0;
  int  settings_loaded = 0;
  int  largest_amount  = 0;
  int  cycle_count     = 0;
  int  send_gap        = 0;
  int  take_gap        = 0;
  bit  idling_on       = 1'b1;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d of %0d requests finished",
               cycle_count, requests_done, requests_queued);
      $display("min_coin_change_dp_top verification failed");
      $finish;
    end
  end

  function automatic void push_status(input status_t st);
    coin_group_t g;
    g.status = st;
    g.slot   = '0;
    g.value  = '0;
    g.count  = '0;
    g.last   = 1'b1;
    groups_due = {groups_due, g};
  endfunction

  // Fewest-coins table, strict compare so ties stay on the lower slot,
  // then traceback and one group per used slot in slot order.
  function automatic void plan_change(input logic [AMT_W-1:0] amount);
    int unsigned fewest  [0:MAX_AMOUNT_DEFAULT];
    int unsigned pick_of [0:MAX_AMOUNT_DEFAULT];
    int unsigned tally   [VALUE_REGS];
    int unsigned slots, best, pick, cand, v, k, s, a, j, last_slot, n_used;
    coin_group_t g;

    slots = 32'(denom_count);
    if (slots > COIN_SLOTS_DEFAULT) slots = COIN_SLOTS_DEFAULT;
    if (slots > VALUE_REGS) slots = VALUE_REGS;
    for (j = 0; j < VALUE_REGS; j++) tally[j] = 0;

    if (amount == 0) begin
      push_status(ST_ZERO);
      return;
    end
    if (amount > MAX_AMOUNT_DEFAULT) begin
      push_status(ST_UNREACH);
      return;
    end

    fewest[0]  = 0;
    pick_of[0] = 0;
    for (a = 1; a <= amount; a++) begin
      best = 32'(UNREACH);
      pick = 0;
      for (j = 0; j < slots; j++) begin
        v = 32'(denom[j]);
        if (v != 0 && v <= a && fewest[a - v] != UNREACH) begin
          cand = fewest[a - v] + 1;
          if (cand > COUNT_SAT) cand = 32'(COUNT_SAT);
          if (cand < best) begin
            best = cand;
            pick = j;
          end
        end
      end
      fewest[a]  = best;
      pick_of[a] = pick;
    end

    if (fewest[amount] == UNREACH) begin
      push_status(ST_UNREACH);
      return;
    end

    k = 32'(amount);
    while (k > 0) begin
      s = pick_of[k] % VALUE_REGS;
      v = 32'(denom[s]);
      if (v == 0 || v > k) break;
      if (tally[s] < TALLY_SAT) tally[s]++;
      k -= v;
    end

    n_used    = 0;
    last_slot = 0;
    for (j = 0; j < VALUE_REGS; j++) begin
      if (tally[j] != 0) begin
        n_used++;
        last_slot = j;
      end
    end
    if (n_used == 0) begin
      push_status(ST_UNREACH);
      return;
    end

    for (j = 0; j < VALUE_REGS; j++) begin
      if (tally[j] != 0) begin
        g.status = ST_GROUP;
        g.slot   = SLOT_W'(j);
        g.value  = denom[j];
        g.count  = TALLY_W'(tally[j]);
        g.last   = (j == last_slot);
        groups_due = {groups_due, g};
      end
    end
  endfunction

  // driver: one request per transaction, valid held until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid         <= 1'b0;
      in_ch.target_amount <= '0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        plan_change(in_ch.target_amount);
        requests_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (amounts_pending.size() != 0) begin
          if (idling_on && $urandom_range(0, 4) == 0) begin
            send_gap = $urandom_range(0, 2);
            in_ch.valid <= 1'b0;
          end else begin
            in_ch.valid         <= 1'b1;
            in_ch.target_amount <= amounts_pending.pop_front();
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result transaction against the oldest coin group
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      take_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        groups_seen++;
        if (groups_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result: st=%0d slot=%0d val=%0d cnt=%0d last=%0b",
                     out_ch.status, out_ch.slot_index, out_ch.slot_value,
                     out_ch.used_count, out_ch.last_group);
        end else begin
          want = groups_due.pop_front();
          if (want.last) requests_done++;
          if (out_ch.status !== want.status || out_ch.slot_index !== want.slot ||
              out_ch.slot_value !== want.value || out_ch.used_count !== want.count ||
              out_ch.last_group !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch at cycle %0d", cycle_count);
              $display("  expected st=%0d slot=%0d val=%0d cnt=%0d last=%0b",
                       want.status, want.slot, want.value, want.count, want.last);
              $display("  actual   st=%0d slot=%0d val=%0d cnt=%0d last=%0b",
                       out_ch.status, out_ch.slot_index, out_ch.slot_value,
                       out_ch.used_count, out_ch.last_group);
            end
          end
        end
      end
      if (take_gap > 0) begin
        take_gap--;
        out_ch.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        take_gap = $urandom_range(0, 2);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic coin_set_t coins(input int v0, v1, v2, v3, v4, v5);
    coins = {v5[VALUE_W-1:0], v4[VALUE_W-1:0], v3[VALUE_W-1:0],
             v2[VALUE_W-1:0], v1[VALUE_W-1:0], v0[VALUE_W-1:0]};
  endfunction

  // leaves valid high; the caller lowers it after the last write
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_COIN_COUNT) denom_count = val[2:0];
    else if (idx <= REG_VALUE_LAST) denom[idx - CFG_IDX_W'(1)] = val;
  endtask

  task automatic load_coins(input logic [2:0] count, input coin_set_t vals);
    int i;
    put_reg(REG_COIN_COUNT, CFG_DATA_W'(count));
    for (i = 0; i < VALUE_REGS; i++)
      put_reg(CFG_IDX_W'(REG_COIN_COUNT + 1 + i), vals[i]);
    cfg_ch.valid <= 1'b0;
    settings_loaded++;
  endtask

  task automatic send(input int amount);
    amounts_pending = {amounts_pending, amount[AMT_W-1:0]};
    requests_queued++;
    if (amount > largest_amount) largest_amount = amount;
  endtask

  // sender holds off until every request of the phase has fully reported
  task automatic wait_drained();
    do @(posedge clk); while (requests_done != requests_queued || !in_ch.ready);
  endtask

  function automatic int rand_amount();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(0, MAX_AMOUNT_DEFAULT);
    return $urandom_range(1, 150);
  endfunction

  initial begin
    int        ph, n, i, r;
    logic [2:0] cnt;
    coin_set_t vals;

    rst_n        = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    denom_count  = 3'd1;
    for (i = 0; i < VALUE_REGS; i++) denom[i] = VALUE_W'(1);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset setting: a single unit coin
    send(0);
    send(1);
    send(MAX_AMOUNT_DEFAULT);
    send(2);
    wait_drained();

    load_coins(3'd4, coins(1, 5, 10, 25, 1023, 1023));
    send(30);
    send(99);
    send(MAX_AMOUNT_DEFAULT);
    wait_drained();

    // ties resolve to the lower slot
    load_coins(3'd3, coins(3, 2, 1, 0, 0, 0));
    send(4);
    send(5);
    send(6);
    wait_drained();

    // odd amounts cannot be made
    load_coins(3'd2, coins(4, 6, 1, 1, 1, 1));
    send(7);
    send(1);
    send(10);
    send(MAX_AMOUNT_DEFAULT);
    wait_drained();

    // no slots in use
    load_coins(3'd0, coins(1, 1, 1, 1, 1, 1));
    send(5);
    send(0);
    wait_drained();

    // count above the slot limit, zero-valued slots, write to an unused index
    put_reg(CFG_IDX_SPARE, '1);
    load_coins(3'd7, coins(0, 1023, 512, 0, 7, 1));
    send(MAX_AMOUNT_DEFAULT);
    send(519);
    send(8);
    wait_drained();

    load_coins(3'd6, coins(1023, 1023, 1023, 1023, 1023, 1023));
    send(MAX_AMOUNT_DEFAULT);
    send(1022);
    wait_drained();

    for (ph = 0; ph < 6; ph++) begin
      if (ph == 5) idling_on = 1'b0;
      cnt = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
                                        : 3'($urandom_range(1, 6));
      for (i = 0; i < VALUE_REGS; i++) begin
        r = $urandom_range(0, 9);
        if (r == 0) vals[i] = '0;
        else if (r == 1) vals[i] = VALUE_W'($urandom_range(1, 1023));
        else vals[i] = VALUE_W'($urandom_range(1, 30));
      end
      if ($urandom_range(0, 1) == 0) vals[0] = 1;
      load_coins(cnt, vals);
      for (n = 0; n < 13; n++) send(rand_amount());
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (groups_due.size() != 0) begin
      mismatches++;
      $display("%0d coin groups never arrived", groups_due.size());
    end

    $display("Ran %0d requests (largest amount %0d) over %0d coin settings",
             requests_sent, largest_amount, settings_loaded);
    $display("Checked %0d result transactions, %0d mismatches", groups_seen, mismatches);
    if (mismatches == 0) begin
      $display("min_coin_change_dp_top verification clean");
    end else begin
      $display("min_coin_change_dp_top verification failed");
    end
    $finish;
  end

endmodule
